[design/glcd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the microcode table of the pixel plotter.
package glcd_pkg;

    localparam int AddrW = 9;
    localparam int WordW = 16;
    localparam int StepW = 5;

    typedef logic [AddrW-1:0] addr_t;
    typedef logic [WordW-1:0] word_t;
    typedef logic [StepW-1:0] step_t;

    localparam step_t STEP_CLEAR  = 5'd0;
    localparam step_t STEP_WAIT   = 5'd1;
    localparam step_t STEP_MODIFY = 5'd2;
    localparam step_t STEP_EMIT0  = 5'd3;
    localparam step_t STEP_LAST   = 5'd23;

    localparam logic [7:0] SYNC_CMD  = 8'hF8;
    localparam logic [7:0] SYNC_DATA = 8'hFA;
    localparam logic [7:0] CMD_EXT0  = 8'h34;
    localparam logic [7:0] CMD_EXT1  = 8'h36;
    localparam logic [7:0] CMD_BASIC = 8'h30;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_WAIT,
        OP_MODIFY,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        PART_SYNC,
        PART_HI,
        PART_LO
    } part_t;

    typedef enum logic [2:0] {
        VAL_EXT0,
        VAL_EXT1,
        VAL_ROW,
        VAL_COL,
        VAL_DHI,
        VAL_DLO,
        VAL_BASIC
    } val_t;

    typedef struct packed {
        op_t   op;
        val_t  val;
        part_t part;
        logic  data;
        logic  last;
        logic  jump;
        step_t target;
    } ucw_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } shd_ctrl_t;

    typedef struct packed {
        logic clear_done;
    } shd_stat_t;

    function automatic ucw_t uc_emit(val_t v, part_t p);
        ucw_t u;
        u.op     = OP_EMIT;
        u.val    = v;
        u.part   = p;
        u.data   = (v == VAL_DHI) || (v == VAL_DLO);
        u.last   = 1'b0;
        u.jump   = 1'b0;
        u.target = STEP_WAIT;
        return u;
    endfunction

    function automatic ucw_t uc_plain(op_t o);
        ucw_t u;
        u.op     = o;
        u.val    = VAL_EXT0;
        u.part   = PART_SYNC;
        u.data   = 1'b0;
        u.last   = 1'b0;
        u.jump   = 1'b0;
        u.target = STEP_WAIT;
        return u;
    endfunction

    // Program: clear wait, input wait, read-modify-write, then 21 emit steps.
    function automatic ucw_t ucode(step_t s);
        ucw_t u;
        case (s)
            STEP_CLEAR:  u = uc_plain(OP_CLEAR);
            STEP_WAIT:   u = uc_plain(OP_WAIT);
            STEP_MODIFY: u = uc_plain(OP_MODIFY);
            STEP_EMIT0:  u = uc_emit(VAL_EXT0, PART_SYNC);
            5'd4:  u = uc_emit(VAL_EXT0, PART_HI);
            5'd5:  u = uc_emit(VAL_EXT0, PART_LO);
            5'd6:  u = uc_emit(VAL_EXT1, PART_SYNC);
            5'd7:  u = uc_emit(VAL_EXT1, PART_HI);
            5'd8:  u = uc_emit(VAL_EXT1, PART_LO);
            5'd9:  u = uc_emit(VAL_ROW, PART_SYNC);
            5'd10: u = uc_emit(VAL_ROW, PART_HI);
            5'd11: u = uc_emit(VAL_ROW, PART_LO);
            5'd12: u = uc_emit(VAL_COL, PART_SYNC);
            5'd13: u = uc_emit(VAL_COL, PART_HI);
            5'd14: u = uc_emit(VAL_COL, PART_LO);
            5'd15: u = uc_emit(VAL_DHI, PART_SYNC);
            5'd16: u = uc_emit(VAL_DHI, PART_HI);
            5'd17: u = uc_emit(VAL_DHI, PART_LO);
            5'd18: u = uc_emit(VAL_DLO, PART_SYNC);
            5'd19: u = uc_emit(VAL_DLO, PART_HI);
            5'd20: u = uc_emit(VAL_DLO, PART_LO);
            5'd21: u = uc_emit(VAL_BASIC, PART_SYNC);
            5'd22: u = uc_emit(VAL_BASIC, PART_HI);
            STEP_LAST:
            begin
                u        = uc_emit(VAL_BASIC, PART_LO);
                u.last   = 1'b1;
                u.jump   = 1'b1;
                u.target = STEP_WAIT;
            end
            default:
            begin
                u        = uc_plain(OP_CLEAR);
                u.jump   = 1'b1;
                u.target = STEP_CLEAR;
            end
        endcase
        return u;
    endfunction

endpackage

[design/graphic_lcd_pixel_plotter.sv]
`timescale 1ns / 1ps
// Top level: microcoded pixel plotter driving the serial command stream of a 128x64 LCD.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel transaction: column, row
//   (0 = bottom) and pixel_on. Output channel (out_valid / out_stall) carries the
//   panel byte stream: 21 transactions per pixel, last marks the final byte.
//   After reset a clearing pass zeroes the 512-word frame shadow, one word per
//   cycle; in_stall stays high through the pass and the clear step's exit.
//   Per pixel: the accept cycle issues the shadow read, one step does the
//   read-modify-write, then 21 steps emit one byte each. From accept to accept an
//   item passes through the modify step, the 21 emit steps and the wait step in
//   which the next pixel is taken.
//   The first byte is loaded into the output register in the first emit step.
//   A stall on the output holds the current byte and freezes the step counter;
//   the next pixel is accepted while the final byte still waits to be taken.
module graphic_lcd_pixel_plotter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [6:0] column,
    input  logic [5:0] row,
    input  logic       pixel_on,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] serial_byte,
    output logic       last
);
    import glcd_pkg::*;

    // sequencer
    step_t      step_reg;
    step_t      step_next;
    ucw_t       uc;
    logic       cond;
    logic       in_accept;
    logic       out_load;

    // captured pixel transaction
    logic [6:0] column_reg;
    logic [5:0] row_reg;
    logic       pixel_on_reg;

    // datapath
    shd_ctrl_t  shd_ctrl;
    shd_stat_t  shd_stat;
    word_t      word;
    logic [5:0] flip;
    logic [7:0] row_addr;
    logic [7:0] col_addr;
    logic [7:0] value;
    logic [7:0] byte_val;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    assign uc        = ucode(step_reg);
    assign in_stall  = (uc.op != OP_WAIT);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = !out_valid_reg || !out_stall;

    // Each step's wait condition; a step advances (or jumps) when it holds.
    always_comb
    begin
        unique case (uc.op)
            OP_CLEAR:  cond = shd_stat.clear_done;
            OP_WAIT:   cond = in_accept;
            OP_MODIFY: cond = 1'b1;
            OP_EMIT:   cond = out_load;
            default:   cond = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (cond)
        begin
            step_next = uc.jump ? uc.target : step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            column_reg   <= column;
            row_reg      <= row;
            pixel_on_reg <= pixel_on;
        end
    end

    // Read is issued straight from the ports on accept; write-back in the modify step.
    assign shd_ctrl.rd = in_accept;
    assign shd_ctrl.wr = (uc.op == OP_MODIFY);

    glcd_shadow u_shadow (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (shd_ctrl),
        .rd_addr  ({row, column[6:4]}),
        .wr_addr  ({row_reg, column_reg[6:4]}),
        .bit_sel  (column_reg[3:0]),
        .pixel_on (pixel_on_reg),
        .word     (word),
        .stat     (shd_stat)
    );

    // Panel row counts from the top; lower half of the panel sits at columns 8..15.
    assign flip     = ~row_reg;
    assign row_addr = {3'b100, flip[4:0]};
    assign col_addr = {4'b1000, flip[5], column_reg[6:4]};

    always_comb
    begin
        unique case (uc.val)
            VAL_EXT0:  value = CMD_EXT0;
            VAL_EXT1:  value = CMD_EXT1;
            VAL_ROW:   value = row_addr;
            VAL_COL:   value = col_addr;
            VAL_DHI:   value = word[15:8];
            VAL_DLO:   value = word[7:0];
            VAL_BASIC: value = CMD_BASIC;
            default:   value = CMD_BASIC;
        endcase
    end

    always_comb
    begin
        unique case (uc.part)
            PART_SYNC: byte_val = uc.data ? SYNC_DATA : SYNC_CMD;
            PART_HI:   byte_val = {value[7:4], 4'b0000};
            PART_LO:   byte_val = {value[3:0], 4'b0000};
            default:   byte_val = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((uc.op == OP_EMIT) && out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((uc.op == OP_EMIT) && out_load)
        begin
            out_byte_reg <= byte_val;
            out_last_reg <= uc.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign serial_byte = out_byte_reg;
    assign last        = out_last_reg;

    // No pixel is taken before the shadow clear has finished.
    a_no_accept_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> shd_stat.clear_done)
        else $error("pixel accepted during shadow clear");

    // An accepted pixel always goes to the read-modify-write step next.
    a_accept_then_modify: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (step_reg == STEP_MODIFY))
        else $error("accept not followed by modify step");

    // A pending non-final byte means the sequence is still in its emit steps.
    a_midstream_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (step_reg >= STEP_EMIT0))
        else $error("mid-stream byte pending outside emit steps");

    // When the final byte leaves, the sequencer waits for a pixel or is in the next modify or first emit step.
    a_last_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && out_last_reg) |->
            ((step_reg == STEP_WAIT) || (step_reg == STEP_MODIFY) ||
             (step_reg == STEP_EMIT0)))
        else $error("final byte taken while sequence still running");

endmodule

[design/glcd_shadow.sv]
`timescale 1ns / 1ps
// Frame shadow memory with post-reset clearing pass and pixel read-modify-write.
module glcd_shadow (
    input  logic                clk,
    input  logic                rst_n,
    input  glcd_pkg::shd_ctrl_t ctrl,
    input  glcd_pkg::addr_t     rd_addr,
    input  glcd_pkg::addr_t     wr_addr,
    input  logic [3:0]          bit_sel,
    input  logic                pixel_on,
    output glcd_pkg::word_t     word,
    output glcd_pkg::shd_stat_t stat
);
    import glcd_pkg::*;

    word_t              mem [2**AddrW];
    word_t              rd_data_reg;
    word_t              word_reg;
    logic [AddrW:0]     clr_cnt_reg;
    logic [AddrW:0]     clr_cnt_next;
    logic               clear_done;
    word_t              mask;
    word_t              new_word;
    logic               we;
    addr_t              waddr;
    word_t              wdata;

    assign clear_done   = clr_cnt_reg[AddrW];
    assign clr_cnt_next = clear_done ? clr_cnt_reg : clr_cnt_reg + 1'b1;

    // bit 15 is the leftmost pixel of the word
    assign mask     = word_t'(1) << (4'd15 - bit_sel);
    assign new_word = pixel_on ? (rd_data_reg | mask) : (rd_data_reg & ~mask);

    assign we    = !clear_done || ctrl.wr;
    assign waddr = clear_done ? wr_addr : clr_cnt_reg[AddrW-1:0];
    assign wdata = clear_done ? new_word : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
        begin
            word_reg <= new_word;
        end
    end

    assign word            = word_reg;
    assign stat.clear_done = clear_done;

endmodule
